// File: sv/srwt_pkg.sv
// package: payload types, codes and defaults for the service registry
package srwt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int NOW_W           = 48;
    localparam int SPAN_W          = 40;
    localparam int ENTRY_W         = 32 + 32 + NOW_W;

    localparam logic [15:0] TPS_RESET = 16'd1000;
    localparam logic [23:0] FRT_RESET = 24'd3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_OFFER = 2'd2;
    localparam logic [1:0] OP_BAD   = 2'd3;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NONE      = 3'd1;
    localparam logic [2:0] ST_OFFERED   = 3'd2;
    localparam logic [2:0] ST_WITHDRAWN = 3'd3;
    localparam logic [2:0] ST_ERROR     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic CFG_TPS = 1'b0;
    localparam logic CFG_FRT = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] req_tag;
        logic [15:0] svc_id;
        logic [15:0] inst_id;
        logic        instance_any;
        logic [23:0] ttl_sec;
        logic [31:0] service_info;
    } t_in;

    typedef struct packed {
        logic [31:0] reply_id;
        logic [2:0]  status;
        logic [15:0] found_service;
        logic [15:0] found_instance;
        logic [31:0] found_info;
        logic [23:0] reply_ttl;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

// File: sv/srwt_ram.sv
// generic single-port-write, registered-read ram
module srwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/service_registry_with_ttl_unit.sv
// Service registry with TTL ageing. Entries (key, descriptor word, 48-bit expiry)
// live in one RAM with a registered read; valid bits are flip-flops.
// A tick gives no beat; an invalid request gives an error beat.
// A find or offer scans the whole table, one entry per cycle while the output
// side does not stall. Find results come out in ascending table order with
// last set on the final beat. Input is stalled while a scan runs.
module service_registry_with_ttl_unit
#(
    parameter int TABLE_DEPTH = srwt_pkg::DEF_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [23:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  srwt_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output srwt_pkg::t_out o_out
);
    import srwt_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [RES_W-1:0] MAXR_C  = RES_W'(MAX_RESULTS);

    t_state r_state, n_state;
    logic [15:0] r_tps;
    logic [23:0] r_frt;
    logic [NOW_W-1:0] r_now, n_now;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    t_in r_req, n_req;
    logic [SPAN_W-1:0] r_span, n_span;
    logic [CNT_W-1:0] r_ra, n_ra;
    logic r_chk_v, n_chk_v;
    logic [IDX_W-1:0] r_chk_idx, n_chk_idx;
    logic [RES_W-1:0] r_nres, n_nres;
    logic r_pend_v, n_pend_v;
    logic [15:0] r_pend_svc, n_pend_svc;
    logic [15:0] r_pend_inst, n_pend_inst;
    logic [31:0] r_pend_info, n_pend_info;
    logic r_ms_v, n_ms_v;
    logic [IDX_W-1:0] r_ms, n_ms;
    logic r_fs_v, n_fs_v;
    logic [IDX_W-1:0] r_fs, n_fs;
    logic r_out_valid, n_out_valid;
    t_out r_out, n_out;

    logic ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [31:0] d_key, d_info;
    logic [NOW_W-1:0] d_exp;
    logic out_free, accept, live, fmatch, kmatch, advance;
    logic [NOW_W:0] exp_sum;
    logic [NOW_W-1:0] exp_sat;
    logic [IDX_W-1:0] slot;

    srwt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH), .AW(IDX_W)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign {d_key, d_info, d_exp} = ram_rdata;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign live   = r_valid[r_chk_idx] && (d_exp > r_now);
    assign fmatch = r_chk_v && (r_req.op == OP_FIND) && live
                    && (d_key[31:16] == r_req.svc_id)
                    && (r_req.instance_any || d_key[15:0] == r_req.inst_id)
                    && (r_nres < MAXR_C);
    assign kmatch = r_chk_v && r_valid[r_chk_idx]
                    && (d_key == {r_req.svc_id, r_req.inst_id});
    assign advance = !(fmatch && r_pend_v && !out_free);

    assign exp_sum = {1'b0, r_now} + (NOW_W + 1)'(r_span);
    assign exp_sat = exp_sum[NOW_W] ? {NOW_W{1'b1}} : exp_sum[NOW_W-1:0];
    assign slot    = r_ms_v ? r_ms : r_fs;

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_valid     = r_valid;
        n_req       = r_req;
        n_span      = r_span;
        n_ra        = r_ra;
        n_chk_v     = r_chk_v;
        n_chk_idx   = r_chk_idx;
        n_nres      = r_nres;
        n_pend_v    = r_pend_v;
        n_pend_svc  = r_pend_svc;
        n_pend_inst = r_pend_inst;
        n_pend_info = r_pend_info;
        n_ms_v      = r_ms_v;
        n_ms        = r_ms;
        n_fs_v      = r_fs_v;
        n_fs        = r_fs;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = slot;
        ram_raddr   = r_ra[IDX_W-1:0];
        ram_wdata   = {r_req.svc_id, r_req.inst_id, r_req.service_info, exp_sat};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req    = i_in;
                    n_span   = SPAN_W'(i_in.ttl_sec) * SPAN_W'(r_tps);
                    n_ra     = '0;
                    n_chk_v  = 1'b0;
                    n_nres   = '0;
                    n_pend_v = 1'b0;
                    n_ms_v   = 1'b0;
                    n_fs_v   = 1'b0;
                    unique case (i_in.op)
                        OP_TICK: n_now = r_now + NOW_W'(1);
                        OP_FIND, OP_OFFER: n_state = S_SCAN;
                        OP_BAD: begin
                            n_out_valid = 1'b1;
                            n_out = '{reply_id: i_in.req_tag, status: ST_ERROR,
                                      found_service: '0, found_instance: '0,
                                      found_info: '0, reply_ttl: '0, last: 1'b1};
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                if (advance) begin
                    if (r_ra < DEPTH_C) begin
                        ram_re    = 1'b1;
                        n_ra      = r_ra + CNT_W'(1);
                        n_chk_v   = 1'b1;
                        n_chk_idx = r_ra[IDX_W-1:0];
                    end else begin
                        n_chk_v = 1'b0;
                        if (!r_chk_v) begin
                            n_state = S_DONE;
                        end
                    end
                    if (fmatch) begin
                        n_nres      = r_nres + RES_W'(1);
                        n_pend_v    = 1'b1;
                        n_pend_svc  = d_key[31:16];
                        n_pend_inst = d_key[15:0];
                        n_pend_info = d_info;
                        if (r_pend_v) begin
                            n_out_valid = 1'b1;
                            n_out = '{reply_id: r_req.req_tag, status: ST_FOUND,
                                      found_service: r_pend_svc,
                                      found_instance: r_pend_inst,
                                      found_info: r_pend_info, reply_ttl: r_frt,
                                      last: 1'b0};
                        end
                    end
                    if (r_req.op == OP_OFFER && r_chk_v) begin
                        if (kmatch && !r_ms_v) begin
                            n_ms_v = 1'b1;
                            n_ms   = r_chk_idx;
                        end
                        if (!live && !r_fs_v) begin
                            n_fs_v = 1'b1;
                            n_fs   = r_chk_idx;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out = '{reply_id: r_req.req_tag, status: ST_NONE,
                              found_service: r_req.svc_id,
                              found_instance: r_req.inst_id,
                              found_info: r_req.service_info,
                              reply_ttl: r_req.ttl_sec, last: 1'b1};
                    if (r_req.op == OP_FIND) begin
                        n_out.reply_ttl = r_frt;
                        if (r_pend_v) begin
                            n_pend_v             = 1'b0;
                            n_out.status         = ST_FOUND;
                            n_out.found_service  = r_pend_svc;
                            n_out.found_instance = r_pend_inst;
                            n_out.found_info     = r_pend_info;
                        end else begin
                            n_out.found_service  = '0;
                            n_out.found_instance = '0;
                            n_out.found_info     = '0;
                        end
                    end else if (r_req.ttl_sec == '0) begin
                        n_out.status = ST_WITHDRAWN;
                        if (r_ms_v) begin
                            n_valid[r_ms] = 1'b0;
                        end
                    end else if (!r_ms_v && !r_fs_v) begin
                        n_out.status = ST_FULL;
                    end else begin
                        n_out.status  = ST_OFFERED;
                        ram_we        = 1'b1;
                        n_valid[slot] = 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tps       <= TPS_RESET;
            r_frt       <= FRT_RESET;
            r_now       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_ms_v      <= 1'b0;
            r_fs_v      <= 1'b0;
            r_nres      <= '0;
            r_ra        <= '0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_chk_v     <= n_chk_v;
            r_pend_v    <= n_pend_v;
            r_ms_v      <= n_ms_v;
            r_fs_v      <= n_fs_v;
            r_nres      <= n_nres;
            r_ra        <= n_ra;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TPS: r_tps <= i_cfg_data[15:0];
                    CFG_FRT: r_frt <= i_cfg_data;
                    default: r_frt <= r_frt;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_span      <= n_span;
        r_chk_idx   <= n_chk_idx;
        r_pend_svc  <= n_pend_svc;
        r_pend_inst <= n_pend_inst;
        r_pend_info <= n_pend_info;
        r_ms        <= n_ms;
        r_fs        <= n_fs;
        r_out       <= n_out;
    end

    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken during scan");

    a_nres_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= MAXR_C)
        else $error("find result count overflow");

    a_pend_find: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_req.op == OP_FIND && r_state != S_IDLE))
        else $error("pending entry outside find");

    a_tick_no_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.op == OP_TICK && !r_out_valid) |=> !r_out_valid)
        else $error("tick produced a beat");
endmodule

// File: test/service_registry_with_ttl_unit_tb.sv
// testbench: service registry with ttl, random and directed requests checked against a predictor
`timescale 1ns / 100ps
module service_registry_with_ttl_unit_tb;
    import srwt_pkg::*;

    localparam int DEPTH = 16;
    localparam int IDLE_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [23:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    service_registry_with_ttl_unit uut (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [15:0] tps;
    logic [23:0] reply_ttl_cfg;
    logic tbl_valid [DEPTH];
    logic [31:0] tbl_key [DEPTH];
    logic [31:0] tbl_info [DEPTH];
    logic [47:0] tbl_expiry [DEPTH];
    logic [47:0] now_ms;

    t_in pending_reqs[$];
    t_out expected_replies[$];
    int errors = 0;
    int beats_in = 0, beats_out = 0, finds_hit = 0, fulls = 0;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;

    // handshakes as seen at the rising edge
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && !o_in_stall;
        out_taken <= i_rst_n && o_out_valid && !i_out_stall;
    end

    function automatic bit is_live(int i);
        return tbl_valid[i] && tbl_expiry[i] > now_ms;
    endfunction

    function automatic t_out make_reply(logic [31:0] rid, logic [2:0] st, logic [15:0] sv,
                                        logic [15:0] inst, logic [31:0] info,
                                        logic [23:0] ttl, logic lst);
        t_out r;
        r.reply_id = rid; r.status = st; r.found_service = sv; r.found_instance = inst;
        r.found_info = info; r.reply_ttl = ttl; r.last = lst;
        return r;
    endfunction

    task automatic predict_registry(t_in q);
        int n;
        int slot;
        logic [31:0] key;
        logic [48:0] exp_sum;
        t_out r;
        n = 0;
        slot = -1;
        key = {q.svc_id, q.inst_id};
        case (q.op)
            OP_TICK: begin
                now_ms = now_ms + 48'd1;
            end
            OP_FIND: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (is_live(i) && tbl_key[i][31:16] == q.svc_id &&
                        (q.instance_any || tbl_key[i][15:0] == q.inst_id)) begin
                        expected_replies = {expected_replies, make_reply(q.req_tag, ST_FOUND,
                            tbl_key[i][31:16], tbl_key[i][15:0], tbl_info[i],
                            reply_ttl_cfg, 1'b0)};
                        n++;
                    end
                end
                if (n == 0)
                    expected_replies = {expected_replies, make_reply(q.req_tag, ST_NONE,
                        '0, '0, '0, reply_ttl_cfg, 1'b1)};
                else begin
                    r = expected_replies.pop_back();
                    r.last = 1'b1;
                    expected_replies = {expected_replies, r};
                    finds_hit++;
                end
            end
            OP_OFFER: begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && tbl_valid[i] && tbl_key[i] == key) slot = i;
                if (q.ttl_sec == 0) begin
                    if (slot >= 0) tbl_valid[slot] = 1'b0;
                    expected_replies = {expected_replies, make_reply(q.req_tag, ST_WITHDRAWN,
                        q.svc_id, q.inst_id, q.service_info, '0, 1'b1)};
                end else begin
                    for (int i = 0; i < DEPTH; i++)
                        if (slot < 0 && !is_live(i)) slot = i;
                    if (slot < 0) begin
                        fulls++;
                        expected_replies = {expected_replies, make_reply(q.req_tag, ST_FULL,
                            q.svc_id, q.inst_id, q.service_info, q.ttl_sec, 1'b1)};
                    end else begin
                        exp_sum = {1'b0, now_ms} + 49'(q.ttl_sec * 64'(tps));
                        tbl_valid[slot] = 1'b1;
                        tbl_key[slot] = key;
                        tbl_info[slot] = q.service_info;
                        tbl_expiry[slot] = exp_sum[48] ? 48'hFFFF_FFFF_FFFF : exp_sum[47:0];
                        expected_replies = {expected_replies, make_reply(q.req_tag, ST_OFFERED,
                            q.svc_id, q.inst_id, q.service_info, q.ttl_sec, 1'b1)};
                    end
                end
            end
            default: begin
                expected_replies = {expected_replies, make_reply(q.req_tag, ST_ERROR,
                    '0, '0, '0, '0, 1'b1)};
            end
        endcase
    endtask

    function automatic t_in make_req(logic [1:0] op, logic [15:0] sv, logic [15:0] inst,
                                     logic any, logic [23:0] ttl);
        t_in q;
        q.op = op; q.req_tag = $urandom; q.svc_id = sv; q.inst_id = inst;
        q.instance_any = any; q.ttl_sec = ttl; q.service_info = $urandom;
        return q;
    endfunction

    // driver
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_taken) begin
                predict_registry(i_in);
                beats_in++;
                send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (pending_reqs.size() > 0 && send_gap == 0) begin
                    i_in <= pending_reqs.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && pending_reqs.size() > 0) begin
                if (send_gap > 0) send_gap--;
                else begin
                    i_in <= pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // receiver stall and long hold-off
    int recv_gap = 0;
    int hold_cnt = 0;
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_out_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= 300) begin
                hold_off <= 1'b0;
                hold_cnt = 0;
            end
        end else if (recv_gap > 0) begin
            recv_gap--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            if (out_taken)
                recv_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_out++;
            if (expected_replies.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %p", $time, o_out);
                errors++;
            end else begin
                t_out e;
                e = expected_replies.pop_front();
                if (o_out.reply_id !== e.reply_id)
                    $display("%0t reply_id exp %h act %h", $time, e.reply_id, o_out.reply_id);
                if (o_out.status !== e.status)
                    $display("%0t status exp %0d act %0d", $time, e.status, o_out.status);
                if (o_out.found_service !== e.found_service)
                    $display("%0t found_service exp %h act %h", $time, e.found_service,
                             o_out.found_service);
                if (o_out.found_instance !== e.found_instance)
                    $display("%0t found_instance exp %h act %h", $time, e.found_instance,
                             o_out.found_instance);
                if (o_out.found_info !== e.found_info)
                    $display("%0t found_info exp %h act %h", $time, e.found_info,
                             o_out.found_info);
                if (o_out.reply_ttl !== e.reply_ttl)
                    $display("%0t reply_ttl exp %h act %h", $time, e.reply_ttl, o_out.reply_ttl);
                if (o_out.last !== e.last)
                    $display("%0t last exp %b act %b", $time, e.last, o_out.last);
                if (o_out !== e) errors++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else if (!hold_off)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !stim_done) begin
            $display("watchdog: no progress, %0d replies outstanding", expected_replies.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic drain_and_settle();
        while (pending_reqs.size() > 0 || i_in_valid || expected_replies.size() > 0 || hold_off)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TPS) tps = val[15:0];
        else reply_ttl_cfg = val;
    endtask

    task automatic random_phase(int count, int svc_span);
        logic [1:0] op;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            op = r < 25 ? OP_TICK : r < 55 ? OP_FIND : r < 95 ? OP_OFFER : OP_BAD;
            pending_reqs = {pending_reqs, make_req(op, 16'($urandom_range(0, svc_span)),
                16'($urandom_range(0, 5)), 1'($urandom),
                ($urandom_range(0, 5) == 0) ? 24'd0 :
                ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(1, 3)))};
            if ($urandom_range(0, 19) == 0) begin
                t_in q;
                logic [127:0] raw;
                raw = {$urandom, $urandom, $urandom, $urandom};
                q = raw[$bits(t_in)-1:0];
                pending_reqs = {pending_reqs, q};
            end
        end
    endtask

    initial begin
        tps = TPS_RESET;
        reply_ttl_cfg = FRT_RESET;
        now_ms = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_valid[i] = 1'b0; tbl_key[i] = '0; tbl_info[i] = '0; tbl_expiry[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, all ops, full table, withdraw
        pending_reqs = {pending_reqs, make_req(OP_FIND, 16'hFFFF, 16'hFFFF, 1'b1, '0)};
        pending_reqs = {pending_reqs, make_req(OP_BAD, 16'hFFFF, 16'hFFFF, 1'b1, 24'hFFFFFF)};
        pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'hFFFF, 16'hFFFF, 1'b0, 24'hFFFFFF)};
        pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'h0000, 16'h0000, 1'b0, 24'd1)};
        for (int i = 0; i < 15; i++)
            pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'h0001, 16'(i), 1'b0, 24'd1)};
        pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'h0002, 16'h0000, 1'b0, 24'd5)};
        pending_reqs = {pending_reqs, make_req(OP_FIND, 16'h0001, 16'h0000, 1'b1, '0)};
        pending_reqs = {pending_reqs, make_req(OP_FIND, 16'h0001, 16'h0003, 1'b0, '0)};
        pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'h0001, 16'h0003, 1'b0, 24'd0)};
        pending_reqs = {pending_reqs, make_req(OP_OFFER, 16'h0009, 16'h0009, 1'b0, 24'd0)};
        pending_reqs = {pending_reqs, make_req(OP_TICK, '0, '0, 1'b0, '0)};
        drain_and_settle();

        // small tps so ticks expire entries
        write_reg(CFG_TPS, 24'd1);
        write_reg(CFG_FRT, 24'hFFFFFF);
        random_phase(150, 3);
        drain_and_settle();

        // long receiver hold-off while the sender keeps sending requests
        write_reg(CFG_TPS, 24'd2);
        write_reg(CFG_FRT, 24'd0);
        random_phase(20, 2);
        @(negedge i_clk);
        hold_off <= 1'b1;
        random_phase(130, 4);
        drain_and_settle();

        // zero and max tps
        write_reg(CFG_TPS, 24'd0);
        random_phase(40, 3);
        drain_and_settle();
        write_reg(CFG_TPS, 24'hFFFF);
        write_reg(CFG_FRT, 24'd3);
        random_phase(80, 6);
        drain_and_settle();
        stim_done = 1'b1;

        $display("sent %0d requests, checked %0d replies, %0d finds with hits, %0d table full",
                 beats_in, beats_out, finds_hit, fulls);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
